// ===== rtl/core/lzss_pkg.sv =====
// Shared types and constants for the LZSS byte decompressor core.
// No dependencies; imported by the decompressor core and the bench checker.
`default_nettype none

package lzss_pkg;

  // History window geometry.
  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned WIN_AW       = 12;

  // Match length field and minimum match.
  localparam int unsigned CNT_W     = 5;
  localparam logic [CNT_W-1:0] MIN_MATCH = 5'd3;

  // Flag position that asks for a fresh flag byte.
  localparam logic [3:0] FLAG_START = 4'd8;

  // Sequencer states: idle takes input, read issues a window read, data emits a copied byte.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DATA
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lzss_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lzss_byte_decompressor_core.sv =====
// LZSS decompressor with a 4096-byte history window held in one synchronous RAM.
// A literal goes straight from its accepted input beat into the output register.
// Flag, literal and match beats are taken in idle while the output slot is free; a match
// then blocks input while each copied byte gets a window read, then emit and write-back.
// Reset: synchronous, active low; clears control state and output_length. The window RAM
// is not cleared and needs no clearing pass, since it is only read where written.
`default_nettype none

module lzss_byte_decompressor_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Compressed input channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  // Decompressed output channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_byte,
  output logic             out_run_last,
  output logic             out_output_full,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_output_length
);

  import lzss_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [3:0]         fpos_r, fpos_nxt;
  logic               phase_r, phase_nxt;
  logic [7:0]         held_r, held_nxt;
  logic [31:0]        produced_r, produced_nxt;
  logic [31:0]        olen_r;
  logic [WIN_AW-1:0]  dist_r, dist_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic               zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_run_last_r, out_run_last_nxt;
  logic               out_full_r, out_full_nxt;

  logic               slot_free;
  logic               room;
  logic               accept;
  logic [31:0]        prod_inc;
  logic               full_next;
  logic               ram_we;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [WIN_AW-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  // Window memory.
  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (produced_r[WIN_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and shared terms.
  assign slot_free = !out_valid_r || out_ready;
  assign room      = produced_r < olen_r;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign prod_inc  = produced_r + 32'd1;
  assign full_next = prod_inc == olen_r;
  assign ram_raddr = produced_r[WIN_AW-1:0] - dist_r;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_run_last_r;
  assign out_output_full = out_full_r;

  // Token decoding and copy sequencing.
  always_comb begin
    logic restart;
    restart          = 1'b0;
    state_nxt        = state_r;
    flags_nxt        = flags_r;
    fpos_nxt         = fpos_r;
    phase_nxt        = phase_r;
    held_nxt         = held_r;
    produced_nxt     = produced_r;
    dist_nxt         = dist_r;
    cnt_nxt          = cnt_r;
    last_nxt         = last_r;
    zero_nxt         = zero_r;
    ram_we           = 1'b0;
    ram_wdata        = in_byte;
    ram_re           = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_byte_nxt     = out_byte_r;
    out_run_last_nxt = out_run_last_r;
    out_full_nxt     = out_full_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          restart = in_last;
          if (room) begin
            if (fpos_r[3]) begin
              flags_nxt = in_byte;
              fpos_nxt  = 4'd0;
              phase_nxt = 1'b0;
            end else if (flags_r[fpos_r[2:0]]) begin
              // Literal: emit and record in the window.
              ram_we           = 1'b1;
              ram_wdata        = in_byte;
              produced_nxt     = prod_inc;
              out_valid_nxt    = 1'b1;
              out_byte_nxt     = in_byte;
              out_run_last_nxt = 1'b1;
              out_full_nxt     = full_next;
              fpos_nxt         = fpos_r + 4'd1;
            end else if (!phase_r) begin
              held_nxt  = in_byte;
              phase_nxt = 1'b1;
            end else begin
              // Second match byte: start the copy; stream restart waits for its end.
              dist_nxt  = {in_byte, held_r[7:4]};
              cnt_nxt   = {1'b0, held_r[3:0]} + MIN_MATCH;
              last_nxt  = in_last;
              restart   = 1'b0;
              phase_nxt = 1'b0;
              fpos_nxt  = fpos_r + 4'd1;
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        // Distances of zero or before the stream start read as zero.
        ram_re    = 1'b1;
        zero_nxt  = (dist_r == '0) || ({20'd0, dist_r} > produced_r);
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (slot_free) begin
          ram_we           = 1'b1;
          ram_wdata        = zero_r ? 8'd0 : ram_rdata;
          produced_nxt     = prod_inc;
          cnt_nxt          = cnt_r - 1'b1;
          out_valid_nxt    = 1'b1;
          out_byte_nxt     = zero_r ? 8'd0 : ram_rdata;
          out_full_nxt     = full_next;
          out_run_last_nxt = (cnt_r == 5'd1) || full_next;
          if ((cnt_r == 5'd1) || full_next) begin
            state_nxt = ST_IDLE;
            restart   = last_r;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // End of stream returns the token state to its reset values.
    if (restart) begin
      flags_nxt    = 8'd0;
      fpos_nxt     = FLAG_START;
      phase_nxt    = 1'b0;
      held_nxt     = 8'd0;
      produced_nxt = 32'd0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flags_r     <= 8'd0;
      fpos_r      <= FLAG_START;
      phase_r     <= 1'b0;
      held_r      <= 8'd0;
      produced_r  <= 32'd0;
      olen_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      fpos_r      <= fpos_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      produced_r  <= produced_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        olen_r <= cfg_output_length;
      end
    end
  end

  // Payload and copy registers.
  always_ff @(posedge clk) begin
    dist_r         <= dist_nxt;
    cnt_r          <= cnt_nxt;
    last_r         <= last_nxt;
    zero_r         <= zero_nxt;
    out_byte_r     <= out_byte_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_full_r     <= out_full_nxt;
  end

  // A window read is always followed by its data phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_DATA)
    else $error("window read not followed by data phase");

  // Every window write comes with a beat placed in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_valid_r)
    else $error("window written without an output beat");

  // A copy never runs with an exhausted length counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA || state_r == ST_READ) |-> cnt_r != '0)
    else $error("copy active with zero remaining length");

endmodule

`default_nettype wire

// ===== bench/lzss_plain_checker.sv =====
`timescale 1ns / 100ps
// Checker for the LZSS byte decompressor: watches the input, output and configuration channels,
// predicts every decompressed beat and compares it field by field. Depends on lzss_pkg.
module lzss_plain_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_run_last,
  input  logic        out_output_full,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_output_length,
  output int          mismatch_count,
  output int          outstanding
);

  import lzss_pkg::*;

  // Which byte of a two-byte match token comes next.
  typedef enum logic {
    TOK_FIRST,
    TOK_SECOND
  } match_half_t;

  // One decompressed beat as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       full;
  } plain_beat_t;

  // Decoder state as the prediction sees it.
  logic [7:0]  hist [WINDOW_DEPTH];
  logic [7:0]  flags;
  logic [3:0]  flag_pos;
  match_half_t half;
  logic [7:0]  held;
  logic [31:0] made;
  logic [31:0] out_len;

  plain_beat_t plain_q [$];
  plain_beat_t burst_q [$];
  plain_beat_t want;
  logic        bad;

  function automatic void restart_stream();
    flags    = 8'h00;
    flag_pos = FLAG_START;
    half     = TOK_FIRST;
    held     = 8'h00;
    made     = 32'd0;
  endfunction

  // Appends one decompressed byte, provided the stream still has room for it.
  function automatic void produce(input logic [7:0] value);
    plain_beat_t beat;
    if (made < out_len) begin
      hist[made[WIN_AW-1:0]] = value;
      made          = made + 32'd1;
      beat.data     = value;
      beat.run_last = 1'b0;
      beat.full     = (made == out_len);
      burst_q.push_back(beat);
    end
  endfunction

  // Works out every beat that one compressed byte releases.
  function automatic void decode_beat(input logic [7:0] b, input logic last);
    logic [11:0] distance;
    logic [4:0]  len;
    logic [31:0] back;
    logic [7:0]  copied;
    plain_beat_t beat;
    int          j;
    burst_q.delete();
    if (made < out_len) begin
      if (flag_pos >= FLAG_START) begin
        flags    = b;
        flag_pos = 4'd0;
        half     = TOK_FIRST;
      end else if (flags[flag_pos[2:0]]) begin
        produce(b);
        flag_pos = flag_pos + 4'd1;
      end else if (half == TOK_FIRST) begin
        held = b;
        half = TOK_SECOND;
      end else begin
        distance = {b, held[7:4]};
        len      = {1'b0, held[3:0]} + MIN_MATCH;
        for (j = 0; j < len && made < out_len; j++) begin
          // A zero distance or one reaching before the stream start copies a zero.
          if (distance == 12'd0 || {20'd0, distance} > made) begin
            copied = 8'h00;
          end else begin
            back   = made - {20'd0, distance};
            copied = hist[back[WIN_AW-1:0]];
          end
          produce(copied);
        end
        half     = TOK_FIRST;
        flag_pos = flag_pos + 4'd1;
      end
    end
    foreach (burst_q[k]) begin
      beat          = burst_q[k];
      beat.run_last = (k == burst_q.size() - 1);
      plain_q.push_back(beat);
    end
    if (last) begin
      restart_stream();
    end
  endfunction

  // Predict on every accepted input beat and compare on every accepted output beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_len = 32'd0;
      restart_stream();
      plain_q.delete();
      mismatch_count <= 0;
      outstanding    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        out_len = cfg_output_length;
      end
      if (in_valid && in_ready) begin
        decode_beat(in_byte, in_last);
      end
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          $error("unexpected output beat: out_byte %02h, out_run_last %0b, out_output_full %0b",
                 out_byte, out_run_last, out_output_full);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = plain_q.pop_front();
          bad  = 1'b0;
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            bad = 1'b1;
          end
          if (out_run_last !== want.run_last) begin
            $error("out_run_last: expected %0b, got %0b", want.run_last, out_run_last);
            bad = 1'b1;
          end
          if (out_output_full !== want.full) begin
            $error("out_output_full: expected %0b, got %0b", want.full, out_output_full);
            bad = 1'b1;
          end
          if (bad) begin
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      outstanding <= plain_q.size();
    end
  end

endmodule

// ===== bench/tb_lzss_byte_decompressor_core.sv =====
`timescale 1ns / 100ps
// Top of the LZSS decompressor bench: clock, reset, compressed stimulus, output back-pressure
// and the verdict. Depends on lzss_byte_decompressor_core and lzss_plain_checker.
module tb_lzss_byte_decompressor_core;

  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD     = 120;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_output_full;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_output_length;
  int          mismatch_count;
  int          outstanding;

  // Stimulus pacing shared with the receiver process.
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          calm = 1'b0;
  bit          long_hold_go = 1'b0;
  bit          long_hold_done = 1'b0;

  // One compressed stream, in_last in bit 8.
  logic [8:0]  stream_q [$];

  lzss_byte_decompressor_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_output_full   (out_output_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_output_length (cfg_output_length)
  );

  lzss_plain_checker u_plain_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_output_full   (out_output_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_output_length (cfg_output_length),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int burst_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off early on, none in the final phase.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one compressed beat, possibly after an idle burst, and waits for its acceptance.
  task automatic send_beat(input logic [7:0] b, input logic l);
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_out_len(input logic [31:0] value);
    cfg_valid         <= 1'b1;
    cfg_output_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted beat has come out, then lets the block finish any work.
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Match distance: mostly within what the stream has produced, sometimes zero or too far back.
  function automatic int pick_distance(input int made);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if ((r < 22 || made == 0) && made < 4095) return $urandom_range(made + 1, 4095);
    if (r < 70) return $urandom_range(1, (made < 16) ? made : 16);
    return $urandom_range(1, made);
  endfunction

  // Builds one stream: mostly well-formed tokens with random content, ending either on a
  // whole token or on a lone first match byte; now and then plain noise.
  task automatic build_stream();
    int         tokens;
    int         made;
    int         distance;
    int         len;
    int         slot;
    int         flag_at;
    int         pick;
    logic [7:0] flag;
    logic [8:0] entry;
    stream_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(3, 12)) stream_q.push_back({1'b0, 8'($urandom)});
      entry    = stream_q[stream_q.size() - 1];
      entry[8] = 1'($urandom_range(0, 1));
      stream_q[stream_q.size() - 1] = entry;
    end else begin
      tokens  = $urandom_range(1, 20);
      made    = 0;
      slot    = 8;
      flag_at = 0;
      flag    = 8'h00;
      repeat (tokens) begin
        if (slot == 8) begin
          flag    = 8'($urandom);
          flag_at = stream_q.size();
          stream_q.push_back({1'b0, flag});
          slot    = 0;
        end
        if (flag[slot]) begin
          stream_q.push_back({1'b0, 8'($urandom)});
          made++;
        end else begin
          len      = $urandom_range(0, 15);
          distance = pick_distance(made);
          stream_q.push_back({1'b0, 4'(distance), 4'(len)});
          stream_q.push_back({1'b0, 8'(distance >> 4)});
          made += len + 3;
        end
        slot++;
      end
      // Lone trailing match byte: force the next flag bit clear and stop after one byte.
      if (pick >= 85) begin
        if (slot == 8) begin
          flag    = 8'($urandom);
          flag[0] = 1'b0;
          stream_q.push_back({1'b0, flag});
        end else begin
          entry       = stream_q[flag_at];
          entry[slot] = 1'b0;
          stream_q[flag_at] = entry;
        end
        stream_q.push_back({1'b0, 8'($urandom)});
      end
      entry    = stream_q[stream_q.size() - 1];
      entry[8] = 1'b1;
      stream_q[stream_q.size() - 1] = entry;
    end
  endtask

  initial begin
    logic [8:0]  opening [17];
    logic [8:0]  capped [9];
    logic [31:0] phase_len [7];
    int          budget;
    int          sent;
    int          p;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_byte           <= 8'h00;
    in_last           <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_output_length <= 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Unlimited output. First stream: literals 00 and FF, an overlapping copy of distance 2
    // and length 18, distance 1, distance 0, the farthest distance (before the stream start)
    // and a lone first match byte carrying in_last. Then a flag byte alone with in_last, and
    // a stream whose first match reaches before the start, closed by a literal.
    opening = '{9'h003, 9'h000, 9'h0FF, 9'h02F, 9'h000, 9'h010, 9'h000, 9'h000, 9'h000,
                9'h0F2, 9'h0FF, 9'h15A, 9'h1FF, 9'h0FE, 9'h010, 9'h000, 9'h1A5};
    write_out_len(32'hFFFF_FFFF);
    foreach (opening[k]) send_beat(opening[k][7:0], opening[k][8]);
    in_valid <= 1'b0;

    // Five bytes allowed: the match fills the output part way, the next byte is ignored
    // until in_last restarts the stream, and a fresh stream produces again.
    capped = '{9'h007, 9'h011, 9'h022, 9'h033, 9'h02F, 9'h000, 9'h155, 9'h001, 9'h166};
    settle();
    write_out_len(32'd5);
    foreach (capped[k]) send_beat(capped[k][7:0], capped[k][8]);
    in_valid <= 1'b0;

    // Random phases, each under its own output length; a phase may stop mid-stream.
    phase_len = '{32'hFFFF_FFFF, 32'd0, 32'($urandom_range(1, 12)),
                  32'($urandom_range(13, 60)), 32'($urandom), 32'd1, 32'hFFFF_FFFF};
    for (p = 0; p < 7; p++) begin
      settle();
      write_out_len(phase_len[p]);
      calm = (p == 6);
      if (p == 0) begin
        long_hold_go = 1'b1;
      end
      budget = (phase_len[p] == 32'd0) ? 8 : 13;
      sent   = 0;
      while (sent < budget) begin
        build_stream();
        tx_idle_pct  = calm ? 0 : burst_pct();
        rx_stall_pct = calm ? 0 : burst_pct();
        foreach (stream_q[k]) begin
          if (sent < budget) begin
            send_beat(stream_q[k][7:0], stream_q[k][8]);
            sent++;
          end
        end
      end
      in_valid <= 1'b0;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== lzss_byte_decompressor_core.f =====
rtl/core/lzss_pkg.sv
rtl/core/lzss_ram.sv
rtl/core/lzss_byte_decompressor_core.sv
bench/lzss_plain_checker.sv
bench/tb_lzss_byte_decompressor_core.sv
